/* hw/rtl/chained_hash_map_defines.svh */
// assertion macros for the chained hash map rtl
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef CHAINED_HASH_MAP_DEFINES_SVH
`define CHAINED_HASH_MAP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CHM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("chained hash map check failed");
`define CHM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("chained hash map check failed");
`else
`define CHM_ASSERT(label, prop)
`define CHM_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* hw/rtl/chm_pkg.sv */
// shared types, widths, codes and the hash round function of the chained hash map
// no dependencies
package chm_pkg;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 4;
  localparam int LOG2_W  = 5;
  localparam int EPOCH_W = 4;
  localparam int STEP_W  = 3;

  localparam logic [CFG_W-1:0]  CFG_RESET = 4'd12;
  localparam logic [STEP_W-1:0] HASH_LAST = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  localparam logic [31:0] HC0 = 32'h7ed55d16;
  localparam logic [31:0] HC1 = 32'hc761c23c;
  localparam logic [31:0] HC2 = 32'h165667b1;
  localparam logic [31:0] HC3 = 32'hd3a2646c;
  localparam logic [31:0] HC4 = 32'hfd7046c5;
  localparam logic [31:0] HC5 = 32'hb55a4f09;

  function automatic logic [31:0] mix_step(input logic [31:0] a, input logic [STEP_W-1:0] step);
    logic [31:0] r;
    unique case (step)
      3'd0:    r = a + HC0 + (a << 12);
      3'd1:    r = a ^ (HC1 ^ (a >> 19));
      3'd2:    r = a + HC2 + (a << 5);
      3'd3:    r = (a + HC3) ^ (a << 9);
      3'd4:    r = a + HC4 + (a << 3);
      3'd5:    r = a ^ HC5 ^ (a >> 16);
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/chm_if.sv */
// valid/ready channel interfaces of the chained hash map: request, response, config
// depends on chm_pkg for field widths
interface chm_in_if;
  logic                       valid;
  logic                       ready;
  logic [chm_pkg::OP_W-1:0]   op;
  logic [chm_pkg::KEY_W-1:0]  key;
  logic [chm_pkg::VAL_W-1:0]  value;
  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface chm_out_if;
  logic                       valid;
  logic                       ready;
  logic [chm_pkg::ST_W-1:0]   status;
  logic [chm_pkg::VAL_W-1:0]  value_out;
  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

interface chm_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [chm_pkg::CFG_W-1:0]  size_log2;
  modport source (output valid, output size_log2, input ready);
  modport sink   (input valid, input size_log2, output ready);
endinterface

/* hw/rtl/chm_fifo.sv */
// two-entry queue between the hashing front end and the table engine
// no package dependency
module chm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/chm_front.sv */
// front end: accepts request transactions and hashes the key one round per cycle
// depends on chm_pkg and chm_in_if; feeds chm_fifo
module chm_front #(
  parameter  int MAX_LOG2_SIZE = 12,
  localparam int IW            = MAX_LOG2_SIZE,
  localparam int QW            = chm_pkg::OP_W + chm_pkg::KEY_W + chm_pkg::VAL_W + IW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [chm_pkg::LOG2_W-1:0]  eff_log2,
  chm_in_if.sink                      in_ch,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [QW-1:0]               q_data
);

  typedef struct packed {
    logic [chm_pkg::OP_W-1:0]  op;
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value;
    logic [IW-1:0]             bucket;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } fstate_t;

  fstate_t                     state_r;
  logic [chm_pkg::STEP_W-1:0]  step_r;
  logic [chm_pkg::OP_W-1:0]    op_r;
  logic [chm_pkg::KEY_W-1:0]   key_r;
  logic [chm_pkg::VAL_W-1:0]   value_r;
  logic [31:0]                 hash_r;
  logic [IW-1:0]               mask;
  item_t                       q_item;

  always_comb begin
    for (int i = 0; i < IW; i++) begin
      mask[i] = (i < int'(eff_log2));
    end
  end

  assign in_ch.ready   = (state_r == F_IDLE);
  assign q_valid       = (state_r == F_PUSH);
  assign q_item.op     = op_r;
  assign q_item.key    = key_r;
  assign q_item.value  = value_r;
  assign q_item.bucket = hash_r[IW-1:0] & mask;
  assign q_data        = q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            op_r    <= in_ch.op;
            key_r   <= in_ch.key;
            value_r <= in_ch.value;
            hash_r  <= in_ch.key;
            step_r  <= '0;
            state_r <= F_HASH;
          end
        end
        F_HASH: begin
          hash_r <= chm_pkg::mix_step(hash_r, step_r);
          step_r <= step_r + 1'b1;
          if (step_r == chm_pkg::HASH_LAST) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/chm_back.sv */
// table engine: bucket head memory with epoch tags, entry store, chain walk, response register
// depends on chm_pkg, chm_out_if and chained_hash_map_defines.svh; fed by chm_fifo
`include "chained_hash_map_defines.svh"

module chm_back #(
  parameter  int MAX_LOG2_SIZE = 12,
  localparam int IW            = MAX_LOG2_SIZE,
  localparam int QW            = chm_pkg::OP_W + chm_pkg::KEY_W + chm_pkg::VAL_W + IW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [chm_pkg::LOG2_W-1:0]  eff_log2,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [QW-1:0]               q_data,
  chm_out_if.source                   out_ch
);

  localparam int PW    = IW + 1;
  localparam int DEPTH = 1 << IW;

  typedef struct packed {
    logic [chm_pkg::OP_W-1:0]  op;
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value;
    logic [IW-1:0]             bucket;
  } item_t;

  typedef struct packed {
    logic [chm_pkg::EPOCH_W-1:0] epoch;
    logic [PW-1:0]               ptr;
  } head_t;

  typedef struct packed {
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value;
    logic [PW-1:0]             next;
  } ent_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_HEAD,
    B_ENTRY,
    B_DONE
  } bstate_t;

  head_t head_mem [DEPTH];
  ent_t  ent_mem  [DEPTH];

  bstate_t                      state_r;
  logic [IW-1:0]                sweep_cnt_r;
  logic [chm_pkg::EPOCH_W-1:0]  epoch_r;
  logic [PW-1:0]                count_r;
  logic                         sweep_pend_r;
  item_t                        cur_r;
  chm_pkg::status_t             res_status_r;
  logic [chm_pkg::VAL_W-1:0]    res_value_r;
  logic                         out_valid_r;
  chm_pkg::status_t             out_status_r;
  logic [chm_pkg::VAL_W-1:0]    out_value_r;
  head_t                        hd_q_r;
  ent_t                         ent_q_r;

  item_t          q_item;
  logic           out_free;
  logic [PW-1:0]  size_w;
  logic           full;
  logic [PW-1:0]  head_ptr;
  logic [PW-1:0]  head_dec;
  logic [PW-1:0]  next_dec;
  logic           key_hit;
  logic           hd_re;
  logic           hd_we;
  logic [IW-1:0]  hd_waddr;
  head_t          hd_wdata;
  logic           ent_re;
  logic [IW-1:0]  ent_raddr;
  logic           ent_we;
  ent_t           ent_wdata;

  assign q_item   = item_t'(q_data);
  assign q_ready  = (state_r == B_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;
  assign size_w   = PW'(1) << eff_log2;
  assign full     = (count_r >= size_w);
  assign head_ptr = (hd_q_r.epoch == epoch_r) ? hd_q_r.ptr : '0;
  assign head_dec = head_ptr - PW'(1);
  assign next_dec = ent_q_r.next - PW'(1);
  assign key_hit  = (ent_q_r.key == cur_r.key);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = out_value_r;

  // memory port control
  always_comb begin
    hd_re     = (state_r == B_IDLE) && q_valid;
    hd_we     = 1'b0;
    hd_waddr  = cur_r.bucket;
    hd_wdata  = '{epoch: epoch_r, ptr: count_r + PW'(1)};
    ent_we    = (state_r == B_HEAD) && (cur_r.op == chm_pkg::OP_INSERT);
    ent_wdata = '{key: cur_r.key, value: cur_r.value, next: head_ptr};
    ent_re    = 1'b0;
    ent_raddr = head_dec[IW-1:0];
    if (state_r == B_SWEEP) begin
      hd_we    = 1'b1;
      hd_waddr = sweep_cnt_r;
      hd_wdata = '0;
    end else if (ent_we) begin
      hd_we = 1'b1;
    end
    if (state_r == B_HEAD && cur_r.op == chm_pkg::OP_LOOKUP && head_ptr != '0) begin
      ent_re = 1'b1;
    end else if (state_r == B_ENTRY && !key_hit && ent_q_r.next != '0) begin
      ent_re    = 1'b1;
      ent_raddr = next_dec[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[hd_waddr] <= hd_wdata;
    end
    if (hd_re) begin
      hd_q_r <= head_mem[q_item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[count_r[IW-1:0]] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_SWEEP;
      sweep_cnt_r  <= '0;
      epoch_r      <= '0;
      count_r      <= '0;
      sweep_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_SWEEP: begin
          sweep_cnt_r <= sweep_cnt_r + 1'b1;
          if (sweep_cnt_r == '1) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_valid) begin
            cur_r        <= q_item;
            res_value_r  <= '0;
            res_status_r <= chm_pkg::ST_OK;
            priority if (q_item.op == chm_pkg::OP_INSERT && full) begin
              res_status_r <= chm_pkg::ST_FULL;
              state_r      <= B_DONE;
            end else if (q_item.op == chm_pkg::OP_INSERT || q_item.op == chm_pkg::OP_LOOKUP) begin
              state_r <= B_HEAD;
            end else if (q_item.op == chm_pkg::OP_CLEAR) begin
              count_r      <= '0;
              epoch_r      <= epoch_r + 1'b1;
              sweep_pend_r <= (epoch_r == '1);
              state_r      <= B_DONE;
            end else begin
              state_r <= B_DONE;
            end
          end
        end
        B_HEAD: begin
          if (cur_r.op == chm_pkg::OP_INSERT) begin
            count_r <= count_r + PW'(1);
            state_r <= B_DONE;
          end else if (head_ptr == '0) begin
            res_status_r <= chm_pkg::ST_NOT_FOUND;
            state_r      <= B_DONE;
          end else begin
            state_r <= B_ENTRY;
          end
        end
        B_ENTRY: begin
          if (key_hit) begin
            res_value_r <= ent_q_r.value;
            state_r     <= B_DONE;
          end else if (ent_q_r.next == '0) begin
            res_status_r <= chm_pkg::ST_NOT_FOUND;
            state_r      <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_value_r  <= res_value_r;
            if (sweep_pend_r) begin
              sweep_pend_r <= 1'b0;
              sweep_cnt_r  <= '0;
              state_r      <= B_SWEEP;
            end else begin
              state_r <= B_IDLE;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `CHM_ASSERT(a_cnt_range, count_r <= PW'(DEPTH))
  `CHM_ASSERT(a_clear_cnt, (state_r == B_IDLE && q_valid && q_item.op == chm_pkg::OP_CLEAR) |=> (count_r == '0))
  `CHM_ASSERT(a_ins_cnt, (state_r == B_HEAD && cur_r.op == chm_pkg::OP_INSERT) |=> (count_r == $past(count_r) + PW'(1)))
  `CHM_ASSERT(a_wrap_sweep, (state_r == B_DONE && out_free && sweep_pend_r) |=> (state_r == B_SWEEP && sweep_cnt_r == '0))

endmodule

/* hw/rtl/chained_hash_map.sv */
// chained hash map top level: size register, front end, queue and table engine
// depends on chm_pkg, chm_if, chm_fifo, chm_front and chm_back
// usage:
//   in_ch carries request transactions (op insert, lookup or clear, key, value);
//   out_ch returns one response per request, in order (status, value_out);
//   cfg_ch writes size_log2; the user must do so only while no request is outstanding,
//   as the block itself leaves it unenforced
//   the front end takes one request at a time: accept, six hash rounds, queue push;
//   in the table engine an insert reads the head and writes entry and head, a lookup
//   reads the head and then the chain one link at a time, and a full refusal, a clear
//   or an unused op goes straight to the response; the two stages overlap through a
//   two-entry queue; from reset, and every 16th clear, all 2^MAX_LOG2_SIZE heads are
//   swept, and the engine takes no request during the sweep
// stall:
//   a response is held in the output register until taken; the engine keeps working
//   up to the next response and the front end keeps accepting until the queue is full
module chained_hash_map #(
  parameter int MAX_LOG2_SIZE = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  chm_in_if.sink      in_ch,
  chm_out_if.source   out_ch,
  chm_cfg_if.sink     cfg_ch
);

  localparam int IW = MAX_LOG2_SIZE;
  localparam int QW = chm_pkg::OP_W + chm_pkg::KEY_W + chm_pkg::VAL_W + IW;

  logic [chm_pkg::CFG_W-1:0]   size_log2_r;
  logic [chm_pkg::LOG2_W-1:0]  size_ext;
  logic [chm_pkg::LOG2_W-1:0]  eff_log2;
  logic                        fq_valid;
  logic                        fq_ready;
  logic [QW-1:0]               fq_data;
  logic                        bq_valid;
  logic                        bq_ready;
  logic [QW-1:0]               bq_data;

  assign cfg_ch.ready = 1'b1;
  assign size_ext     = {1'b0, size_log2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= chm_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      size_log2_r <= cfg_ch.size_log2;
    end
  end

  // clamp to the supported range
  always_comb begin
    priority if (size_ext < chm_pkg::LOG2_W'(1)) begin
      eff_log2 = chm_pkg::LOG2_W'(1);
    end else if (size_ext > chm_pkg::LOG2_W'(MAX_LOG2_SIZE)) begin
      eff_log2 = chm_pkg::LOG2_W'(MAX_LOG2_SIZE);
    end else begin
      eff_log2 = size_ext;
    end
  end

  chm_front #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_log2 (eff_log2),
    .in_ch    (in_ch),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  chm_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_data)
  );

  chm_back #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_log2 (eff_log2),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_data   (bq_data),
    .out_ch   (out_ch)
  );

endmodule
